@@ hdl/svkstr_pkg.sv @@
// ============================================================================
// svkstr_pkg
// Types and constants for the St Venant-Kirchhoff stress pipeline.
// ============================================================================
`default_nettype none

package svkstr_pkg;

    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SHEAR_MODULUS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LAME_LAMBDA   = 1'd1;

    localparam logic [31:0] SHEAR_MODULUS_RST = 32'd65536;
    localparam logic [31:0] LAME_LAMBDA_RST   = 32'd65536;

    // identity at Q.48 in the 65-bit Cauchy-Green sum
    localparam logic signed [64:0] ONE_Q48 = 65'sh1_0000_0000_0000;

    localparam logic [47:0] STRESS_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] STRESS_NEG_MIN = 48'h8000_0000_0000;

    // symmetric 3x3 storage: (0,0) (0,1) (0,2) (1,1) (1,2) (2,2)
    localparam int unsigned NUM_SYM = 6;
    localparam int unsigned SYM_ROW [NUM_SYM] = '{0, 0, 0, 1, 1, 2};
    localparam int unsigned SYM_COL [NUM_SYM] = '{0, 1, 2, 1, 2, 2};
    localparam bit          SYM_DIAG[NUM_SYM] = '{1, 0, 0, 1, 0, 1};
    // full row-major index -> symmetric slot
    localparam int unsigned SYM_OF  [9]       = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

    typedef struct packed {
        logic signed [31:0] f_r0c0;
        logic signed [31:0] f_r0c1;
        logic signed [31:0] f_r0c2;
        logic signed [31:0] f_r1c0;
        logic signed [31:0] f_r1c1;
        logic signed [31:0] f_r1c2;
        logic signed [31:0] f_r2c0;
        logic signed [31:0] f_r2c1;
        logic signed [31:0] f_r2c2;
        logic        [31:0] rest_volume;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] p_r0c0;
        logic signed [47:0] p_r0c1;
        logic signed [47:0] p_r0c2;
        logic signed [47:0] p_r1c0;
        logic signed [47:0] p_r1c1;
        logic signed [47:0] p_r1c2;
        logic signed [47:0] p_r2c0;
        logic signed [47:0] p_r2c1;
        logic signed [47:0] p_r2c2;
        logic        [63:0] element_energy;
        logic               saturated;
    } out_item_t;

endpackage

`default_nettype wire

@@ hdl/svk_green_strain_piola_stress_unit.sv @@
// ============================================================================
// svk_green_strain_piola_stress_unit
// Green strain, St Venant-Kirchhoff second stress, first Piola stress and
// element energy for one 3x3 deformation gradient per transfer.
// ============================================================================
//
//  channel   ports                        payload       direction
//  -------   --------------------------   -----------   ---------
//  input     s_valid / s_ready / s_data   in_item_t     in
//  result    m_valid / m_ready / m_data   out_item_t    out
//  config    cfg_we / cfg_addr / cfg_wdata  mu, lambda  in
//
//  One input transfer per cycle sustained while m_ready does not stall the
//  result channel. Each transfer passes through the 11-stage pipeline
//  (32x32 partial products, each followed by its own add stage).
//  Each stage has a valid bit and its own load enable; a stage loads when it
//  is empty or the stage after it moves, so bubbles close up under a stall
//  and nothing is dropped or repeated.
//  aresetn (synchronous, active low) clears the valid bits and sets mu and
//  lambda to 1.0; data registers are not reset.
//
`default_nettype none

module svk_green_strain_piola_stress_unit (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  svkstr_pkg::in_item_t                 s_data,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output svkstr_pkg::out_item_t                m_data,
    input  wire                                  cfg_we,
    input  wire  [svkstr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire  [svkstr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import svkstr_pkg::*;

    localparam int unsigned NSTG = 11;

    // ------------------------------------------------------------------
    // configuration registers (the user writes them only while the pipe is empty; the block does not enforce it)
    // ------------------------------------------------------------------
    logic [31:0] shear_modulus_reg;
    logic [31:0] lame_lambda_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shear_modulus_reg <= SHEAR_MODULUS_RST;
            lame_lambda_reg   <= LAME_LAMBDA_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SHEAR_MODULUS: shear_modulus_reg <= cfg_wdata;
                REG_LAME_LAMBDA:   lame_lambda_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic [NSTG:1] valid_reg;
    logic [NSTG:1] stage_en;

    always_comb begin
        stage_en[NSTG] = !valid_reg[NSTG] || m_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[1]) begin
                valid_reg[1] <= s_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = stage_en[1];
    assign m_valid = valid_reg[NSTG];

    // F and volume ride along until they are used
    logic signed [31:0] f_in [9];
    logic signed [31:0] f_pipe_reg [1:5][9];
    logic        [31:0] vol_pipe_reg [1:9];

    always_comb begin
        f_in[0] = s_data.f_r0c0;
        f_in[1] = s_data.f_r0c1;
        f_in[2] = s_data.f_r0c2;
        f_in[3] = s_data.f_r1c0;
        f_in[4] = s_data.f_r1c1;
        f_in[5] = s_data.f_r1c2;
        f_in[6] = s_data.f_r2c0;
        f_in[7] = s_data.f_r2c1;
        f_in[8] = s_data.f_r2c2;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            f_pipe_reg[1]   <= f_in;
            vol_pipe_reg[1] <= s_data.rest_volume;
        end
        for (int k = 2; k <= 5; k++) begin
            if (stage_en[k]) begin
                f_pipe_reg[k] <= f_pipe_reg[k-1];
            end
        end
        for (int k = 2; k <= 9; k++) begin
            if (stage_en[k]) begin
                vol_pipe_reg[k] <= vol_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: F^T F products, Q.48
    // ------------------------------------------------------------------
    logic signed [63:0] ff_next [NUM_SYM][3];
    logic signed [63:0] ff_reg  [NUM_SYM][3];

    always_comb begin
        for (int u = 0; u < NUM_SYM; u++) begin
            for (int k = 0; k < 3; k++) begin
                ff_next[u][k] = f_in[k*3 + SYM_ROW[u]] * f_in[k*3 + SYM_COL[u]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) ff_reg <= ff_next;
    end

    // ------------------------------------------------------------------
    // stage 2: E = (C - I)/2, floored to Q.32 (stress) and Q.24 (energy)
    // ------------------------------------------------------------------
    logic signed [47:0] e32_next [NUM_SYM];
    logic signed [39:0] e24_next [NUM_SYM];
    logic signed [47:0] e32_reg  [NUM_SYM];
    logic signed [39:0] e24_reg  [NUM_SYM];

    always_comb begin
        logic signed [64:0] c_sum;
        for (int u = 0; u < NUM_SYM; u++) begin
            c_sum = 65'(ff_reg[u][0]) + 65'(ff_reg[u][1]) + 65'(ff_reg[u][2]);
            if (SYM_DIAG[u]) c_sum = c_sum - ONE_Q48;
            e32_next[u] = c_sum[64:17];
            e24_next[u] = c_sum[64:25];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            e32_reg <= e32_next;
            e24_reg <= e24_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: traces; partial products of the Q.24 strain squares
    // ------------------------------------------------------------------
    logic signed [49:0] tr32_next, tr32_reg;
    logic signed [41:0] tr24_next, tr24_reg;
    logic        [63:0] sqll_next [NUM_SYM];
    logic signed [40:0] sqhl_next [NUM_SYM];
    logic signed [15:0] sqhh_next [NUM_SYM];
    logic        [63:0] sqll_reg  [NUM_SYM];
    logic signed [40:0] sqhl_reg  [NUM_SYM];
    logic signed [15:0] sqhh_reg  [NUM_SYM];
    logic signed [47:0] e32_3_reg [NUM_SYM];

    always_comb begin
        tr32_next = 50'(e32_reg[0]) + 50'(e32_reg[3]) + 50'(e32_reg[5]);
        tr24_next = 42'(e24_reg[0]) + 42'(e24_reg[3]) + 42'(e24_reg[5]);
        for (int u = 0; u < NUM_SYM; u++) begin
            sqll_next[u] = e24_reg[u][31:0] * e24_reg[u][31:0];
            sqhl_next[u] = $signed(e24_reg[u][39:32]) * $signed({1'b0, e24_reg[u][31:0]});
            sqhh_next[u] = $signed(e24_reg[u][39:32]) * $signed(e24_reg[u][39:32]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            tr32_reg  <= tr32_next;
            tr24_reg  <= tr24_next;
            sqll_reg  <= sqll_next;
            sqhl_reg  <= sqhl_next;
            sqhh_reg  <= sqhh_next;
            e32_3_reg <= e32_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: squares summed; mu*E, lambda*tr(E), tr(E)^2 partials
    // ------------------------------------------------------------------
    logic        [78:0] sq_next  [NUM_SYM];
    logic        [78:0] sq_reg   [NUM_SYM];
    logic        [63:0] mul_next [NUM_SYM];
    logic signed [48:0] muh_next [NUM_SYM];
    logic        [63:0] mul_reg  [NUM_SYM];
    logic signed [48:0] muh_reg  [NUM_SYM];
    logic        [63:0] ltl_next, ltl_reg;
    logic signed [50:0] lth_next, lth_reg;
    logic        [63:0] tll_next, tll_reg;
    logic signed [42:0] thl_next, thl_reg;
    logic signed [19:0] thh_next, thh_reg;

    always_comb begin
        logic signed [79:0] sq_wide;
        for (int u = 0; u < NUM_SYM; u++) begin
            sq_wide = 80'($signed({sqhh_reg[u], 64'd0}))
                    + 80'($signed({sqhl_reg[u], 33'd0}))
                    + $signed({16'd0, sqll_reg[u]});
            sq_next[u]  = sq_wide[78:0];
            mul_next[u] = shear_modulus_reg * e32_3_reg[u][31:0];
            muh_next[u] = $signed({1'b0, shear_modulus_reg}) * $signed(e32_3_reg[u][47:32]);
        end
        ltl_next = lame_lambda_reg * tr32_reg[31:0];
        lth_next = $signed({1'b0, lame_lambda_reg}) * $signed(tr32_reg[49:32]);
        tll_next = tr24_reg[31:0] * tr24_reg[31:0];
        thl_next = $signed(tr24_reg[41:32]) * $signed({1'b0, tr24_reg[31:0]});
        thh_next = $signed(tr24_reg[41:32]) * $signed(tr24_reg[41:32]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            sq_reg  <= sq_next;
            mul_reg <= mul_next;
            muh_reg <= muh_next;
            ltl_reg <= ltl_next;
            lth_reg <= lth_next;
            tll_reg <= tll_next;
            thl_reg <= thl_next;
            thh_reg <= thh_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: S floored to Q.24; sum of squares halves; tr(E)^2
    // ------------------------------------------------------------------
    logic signed [58:0] s_next [NUM_SYM];
    logic signed [58:0] s_reg  [NUM_SYM];
    logic        [80:0] qd_next, qo_next, qd_reg, qo_reg;
    logic        [81:0] trsq_next, trsq_reg;

    always_comb begin
        logic signed [83:0] lam_term;
        logic signed [83:0] s_acc;
        logic signed [83:0] trsq_wide;
        lam_term = 84'($signed({lth_reg, 32'd0})) + $signed({20'd0, ltl_reg});
        for (int u = 0; u < NUM_SYM; u++) begin
            s_acc = 84'($signed({muh_reg[u], 33'd0}))
                  + $signed({19'd0, mul_reg[u], 1'b0})
                  + (SYM_DIAG[u] ? lam_term : 84'sd0);
            s_next[u] = s_acc[82:24];
        end
        qd_next = 81'(sq_reg[0]) + 81'(sq_reg[3]) + 81'(sq_reg[5]);
        qo_next = 81'(sq_reg[1]) + 81'(sq_reg[2]) + 81'(sq_reg[4]);
        trsq_wide = 84'($signed({thh_reg, 64'd0}))
                  + 84'($signed({thl_reg, 33'd0}))
                  + $signed({20'd0, tll_reg});
        trsq_next = trsq_wide[81:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            s_reg    <= s_next;
            qd_reg   <= qd_next;
            qo_reg   <= qo_next;
            trsq_reg <= trsq_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: F*S partial products; full sum of squares
    // ------------------------------------------------------------------
    logic signed [64:0] psl_next [9][3];
    logic signed [58:0] psh_next [9][3];
    logic signed [64:0] psl_reg  [9][3];
    logic signed [58:0] psh_reg  [9][3];
    logic        [81:0] q_next, q_reg;
    logic        [81:0] trsq_6_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    psl_next[i*3+j][k] = f_pipe_reg[5][i*3+k]
                        * $signed({1'b0, s_reg[SYM_OF[k*3+j]][31:0]});
                    psh_next[i*3+j][k] = f_pipe_reg[5][i*3+k]
                        * $signed(s_reg[SYM_OF[k*3+j]][58:32]);
                end
            end
        end
        // off-diagonal strain terms appear twice in tr(E E)
        q_next = 82'(qd_reg) + {qo_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            psl_reg    <= psl_next;
            psh_reg    <= psh_next;
            q_reg      <= q_next;
            trsq_6_reg <= trsq_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: F*S products joined; mu*q and lambda*tr^2 limbs
    // ------------------------------------------------------------------
    logic signed [90:0] pr_next [9][3];
    logic signed [90:0] pr_reg  [9][3];
    logic [63:0] mq0_next, mq1_next, lq0_next, lq1_next;
    logic [49:0] mq2_next, lq2_next;
    logic [63:0] mq0_reg, mq1_reg, lq0_reg, lq1_reg;
    logic [49:0] mq2_reg, lq2_reg;

    always_comb begin
        for (int m = 0; m < 9; m++) begin
            for (int k = 0; k < 3; k++) begin
                pr_next[m][k] = 91'($signed({psh_reg[m][k], 32'd0})) + 91'(psl_reg[m][k]);
            end
        end
        mq0_next = shear_modulus_reg * q_reg[31:0];
        mq1_next = shear_modulus_reg * q_reg[63:32];
        mq2_next = shear_modulus_reg * q_reg[81:64];
        lq0_next = lame_lambda_reg * trsq_6_reg[31:0];
        lq1_next = lame_lambda_reg * trsq_6_reg[63:32];
        lq2_next = lame_lambda_reg * trsq_6_reg[81:64];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            pr_reg  <= pr_next;
            mq0_reg <= mq0_next;
            mq1_reg <= mq1_next;
            mq2_reg <= mq2_next;
            lq0_reg <= lq0_next;
            lq1_reg <= lq1_next;
            lq2_reg <= lq2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: P sums floored to Q.24; energy terms joined
    // ------------------------------------------------------------------
    logic signed [67:0] p_next [9];
    logic signed [67:0] p_reg  [9];
    logic [113:0] muq_next, lamt_next, muq_reg, lamt_reg;

    always_comb begin
        logic signed [91:0] p_acc;
        for (int m = 0; m < 9; m++) begin
            p_acc = 92'(pr_reg[m][0]) + 92'(pr_reg[m][1]) + 92'(pr_reg[m][2]);
            p_next[m] = p_acc[91:24];
        end
        muq_next  = {mq2_reg, 64'd0} + 114'({mq1_reg, 32'd0}) + 114'(mq0_reg);
        lamt_next = {lq2_reg, 64'd0} + 114'({lq1_reg, 32'd0}) + 114'(lq0_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            p_reg    <= p_next;
            muq_reg  <= muq_next;
            lamt_reg <= lamt_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: 2 psi at Q.64; P clamped to 48 bits
    // ------------------------------------------------------------------
    logic [115:0] psi_next, psi_reg;
    logic [47:0]  pout_next [9];
    logic [47:0]  pout_9_reg [9];
    logic         psat_next, psat_9_reg;

    always_comb begin
        psi_next  = 116'({muq_reg, 1'b0}) + 116'(lamt_reg);
        psat_next = 1'b0;
        for (int m = 0; m < 9; m++) begin
            if ((&p_reg[m][67:47]) || !(|p_reg[m][67:47])) begin
                pout_next[m] = p_reg[m][47:0];
            end else if (p_reg[m][67]) begin
                pout_next[m] = STRESS_NEG_MIN;
                psat_next    = 1'b1;
            end else begin
                pout_next[m] = STRESS_POS_MAX;
                psat_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[9]) begin
            psi_reg    <= psi_next;
            pout_9_reg <= pout_next;
            psat_9_reg <= psat_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: floor(2 psi) at Q.32 times volume, by limbs
    // ------------------------------------------------------------------
    logic [63:0] hv0_next, hv1_next, hv0_reg, hv1_reg;
    logic [51:0] hv2_next, hv2_reg;
    logic [47:0] pout_10_reg [9];
    logic        psat_10_reg;

    always_comb begin
        hv0_next = vol_pipe_reg[9] * psi_reg[63:32];
        hv1_next = vol_pipe_reg[9] * psi_reg[95:64];
        hv2_next = vol_pipe_reg[9] * psi_reg[115:96];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[10]) begin
            hv0_reg     <= hv0_next;
            hv1_reg     <= hv1_next;
            hv2_reg     <= hv2_next;
            pout_10_reg <= pout_9_reg;
            psat_10_reg <= psat_9_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 11: halve to Q.32, clamp energy, output register
    // ------------------------------------------------------------------
    out_item_t out_next, out_reg;

    always_comb begin
        logic [115:0] ev;
        logic         esat;
        ev   = {hv2_reg, 64'd0} + 116'({hv1_reg, 32'd0}) + 116'(hv0_reg);
        esat = |ev[115:89];
        out_next.p_r0c0 = pout_10_reg[0];
        out_next.p_r0c1 = pout_10_reg[1];
        out_next.p_r0c2 = pout_10_reg[2];
        out_next.p_r1c0 = pout_10_reg[3];
        out_next.p_r1c1 = pout_10_reg[4];
        out_next.p_r1c2 = pout_10_reg[5];
        out_next.p_r2c0 = pout_10_reg[6];
        out_next.p_r2c1 = pout_10_reg[7];
        out_next.p_r2c2 = pout_10_reg[8];
        out_next.element_energy = esat ? '1 : ev[88:25];
        out_next.saturated      = esat || psat_10_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[11]) out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

@@ tb/svk_stress_checker.sv @@
// ----------------------------------------------------------------------------
// svk_stress_checker
// Watches the input and result channels of the stress unit, works out the
// Piola stress and element energy for every accepted transfer and compares
// each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module svk_stress_checker (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    input  wire                   s_ready,
    input  svkstr_pkg::in_item_t  s_data,
    input  wire                   m_valid,
    input  wire                   m_ready,
    input  svkstr_pkg::out_item_t m_data,
    input  wire                   cfg_we,
    input  wire  [svkstr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire  [svkstr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import svkstr_pkg::*;

    logic [31:0] mu_q16;
    logic [31:0] lambda_q16;
    out_item_t   stress_queue[$];

    assign pending = stress_queue.size();

    function automatic logic [47:0] clamp48(logic signed [159:0] v, ref bit sat);
        if (v > 160'sh7FFF_FFFF_FFFF) begin
            sat = 1;
            return STRESS_POS_MAX;
        end
        if (v < -160'sh8000_0000_0000) begin
            sat = 1;
            return STRESS_NEG_MIN;
        end
        return v[47:0];
    endfunction

    function automatic out_item_t piola_energy(in_item_t d);
        logic signed [159:0] f[9], e32[9], e24[9], s24[9];
        logic signed [159:0] acc, tr32, tr24, q, psi2, mu, lam;
        logic [47:0] p[9];
        out_item_t r;
        bit sat;
        sat = 0;
        mu = $signed({128'd0, mu_q16});
        lam = $signed({128'd0, lambda_q16});
        f[0] = d.f_r0c0; f[1] = d.f_r0c1; f[2] = d.f_r0c2;
        f[3] = d.f_r1c0; f[4] = d.f_r1c1; f[5] = d.f_r1c2;
        f[6] = d.f_r2c0; f[7] = d.f_r2c1; f[8] = d.f_r2c2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += f[k*3+i] * f[k*3+j];
                if (i == j)
                    acc -= 160'sd1 <<< 48;
                e32[i*3+j] = acc >>> 17;
                e24[i*3+j] = acc >>> 25;
            end
        tr32 = e32[0] + e32[4] + e32[8];
        tr24 = e24[0] + e24[4] + e24[8];
        for (int i = 0; i < 9; i++) begin
            acc = 2 * mu * e32[i];
            if (i % 4 == 0)
                acc += lam * tr32;
            s24[i] = acc >>> 24;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += f[i*3+k] * s24[k*3+j];
                p[i*3+j] = clamp48(acc >>> 24, sat);
            end
        q = 0;
        for (int i = 0; i < 9; i++)
            q += e24[i] * e24[i];
        psi2 = 2 * q * mu + tr24 * tr24 * lam;
        acc = ((psi2 >>> 32) * $signed({128'd0, d.rest_volume})) >>> 25;
        if (acc > 160'sh0FFFF_FFFF_FFFF_FFFF) begin
            sat = 1;
            r.element_energy = '1;
        end else begin
            r.element_energy = acc[63:0];
        end
        r.p_r0c0 = p[0]; r.p_r0c1 = p[1]; r.p_r0c2 = p[2];
        r.p_r1c0 = p[3]; r.p_r1c1 = p[4]; r.p_r1c2 = p[5];
        r.p_r2c0 = p[6]; r.p_r2c1 = p[7]; r.p_r2c2 = p[8];
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            mu_q16 <= SHEAR_MODULUS_RST;
            lambda_q16 <= LAME_LAMBDA_RST;
        end else begin
            if (cfg_we && cfg_addr == REG_SHEAR_MODULUS)
                mu_q16 <= cfg_wdata;
            if (cfg_we && cfg_addr == REG_LAME_LAMBDA)
                lambda_q16 <= cfg_wdata;
            if (s_valid && s_ready)
                stress_queue.push_back(piola_energy(s_data));
            if (m_valid && m_ready) begin
                if (stress_queue.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = stress_queue.pop_front();
                    if (m_data.p_r0c0 !== want.p_r0c0) report_mismatch("p_r0c0", m_data.p_r0c0, want.p_r0c0);
                    if (m_data.p_r0c1 !== want.p_r0c1) report_mismatch("p_r0c1", m_data.p_r0c1, want.p_r0c1);
                    if (m_data.p_r0c2 !== want.p_r0c2) report_mismatch("p_r0c2", m_data.p_r0c2, want.p_r0c2);
                    if (m_data.p_r1c0 !== want.p_r1c0) report_mismatch("p_r1c0", m_data.p_r1c0, want.p_r1c0);
                    if (m_data.p_r1c1 !== want.p_r1c1) report_mismatch("p_r1c1", m_data.p_r1c1, want.p_r1c1);
                    if (m_data.p_r1c2 !== want.p_r1c2) report_mismatch("p_r1c2", m_data.p_r1c2, want.p_r1c2);
                    if (m_data.p_r2c0 !== want.p_r2c0) report_mismatch("p_r2c0", m_data.p_r2c0, want.p_r2c0);
                    if (m_data.p_r2c1 !== want.p_r2c1) report_mismatch("p_r2c1", m_data.p_r2c1, want.p_r2c1);
                    if (m_data.p_r2c2 !== want.p_r2c2) report_mismatch("p_r2c2", m_data.p_r2c2, want.p_r2c2);
                    if (m_data.element_energy !== want.element_energy)
                        report_mismatch("element_energy", m_data.element_energy, want.element_energy);
                    if (m_data.saturated !== want.saturated)
                        report_mismatch("saturated", m_data.saturated, want.saturated);
                end
            end
        end
    end
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives deformation gradients and rest volumes into the stress unit under
// bursty input and a stalling receiver, changes the Lame constants between
// phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import svkstr_pkg::*;

    localparam int PIPE_DEPTH = 11;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_item_t m_data;
    logic cfg_we = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_SHEAR_MODULUS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int fail_count;
    int pending;
    int cycle_count = 0;
    bit stall_on = 1;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    svk_green_strain_piola_stress_unit dut (.*);

    svk_stress_checker checker_i (.*);

    // receiver: stall pattern of its own, switched off in one phase
    always @(posedge aclk) begin
        if (!stall_on)
            m_ready <= 1;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    // global timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Q8.24 helpers: near-identity entries keep most results in range
    function automatic logic [31:0] near_one(bit diag);
        logic signed [31:0] base;
        base = diag ? 32'sh0100_0000 : 32'sh0;
        return base + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endfunction

    function automatic in_item_t random_gradient();
        in_item_t d;
        logic [31:0] v[9];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0:       v[i] = $urandom();                   // full range, saturates
                1:       v[i] = $urandom() >>> $urandom_range(4, 24);
                default: v[i] = near_one(i % 4 == 0);
            endcase
            if (kind == 1 && $urandom_range(0, 1)) v[i] = -v[i];
        end
        d = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
             ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0400_0000)};
        return d;
    endfunction

    // one transfer; valid stays up across back-to-back items
    task automatic send_gradient(in_item_t d, bit keep_valid);
        s_valid <= 1;
        s_data <= d;
        do @(posedge aclk); while (!s_ready);
        if (!keep_valid)
            s_valid <= 0;
    endtask

    task automatic drain_pipe();
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && left > 0; b++) begin
                left--;
                send_gradient(random_gradient(), b + 1 < burst && left > 0);
            end
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    initial begin
        in_item_t d;
        logic [31:0] mu_set[5];
        logic [31:0] lam_set[5];
        mu_set = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0003_4000};
        lam_set = '{32'hFFFF_FFFF, 32'h0, 32'h0002_0000, 32'h0000_0001, 32'h0010_0000};

        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: identity, zero, field extremes, stretch, shear, volumes
        d = '0;
        send_gradient(d, 1);
        d.f_r0c0 = 32'sh0100_0000; d.f_r1c1 = 32'sh0100_0000; d.f_r2c2 = 32'sh0100_0000;
        d.rest_volume = 32'h0100_0000;
        send_gradient(d, 1);
        d.f_r0c0 = 32'sh0200_0000;
        send_gradient(d, 1);
        d.f_r0c1 = 32'sh0040_0000;
        d.rest_volume = 32'hFFFF_FFFF;
        send_gradient(d, 1);
        d = {10{32'h7FFF_FFFF}};
        send_gradient(d, 1);
        d = {10{32'h8000_0000}};
        send_gradient(d, 1);
        d = {10{32'hFFFF_FFFF}};
        send_gradient(d, 1);
        d = {10{32'h0000_0001}};
        send_gradient(d, 1);
        d = {{9{32'hF000_0000}}, 32'h0000_0000};
        send_gradient(d, 1);
        for (int i = 0; i < 8; i++)
            send_gradient(random_gradient(), i < 7);

        // hold off until every result has drained
        drain_pipe();
        random_phase(100);

        // sweep the constants; registers only change while idle
        for (int ph = 0; ph < 5; ph++) begin
            drain_pipe();
            write_reg(REG_SHEAR_MODULUS, mu_set[ph]);
            write_reg(REG_LAME_LAMBDA, lam_set[ph]);
            stall_on = (ph != 2);
            random_phase(150);
        end

        drain_pipe();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/svkstr_pkg.sv
hdl/svk_green_strain_piola_stress_unit.sv
tb/svk_stress_checker.sv
tb/testbench.sv
